FILE: sv/sirlat_pkg.sv
// Shared types and constants for the SIR lattice update block.
`timescale 1ns / 1ps

package sirlat_pkg;

  // Cell states
  localparam logic [1:0] CELL_SUSC = 2'd0;
  localparam logic [1:0] CELL_INF  = 2'd1;
  localparam logic [1:0] CELL_REC  = 2'd2;

  // Request types
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // Neighbour directions
  localparam logic [1:0] DIR_ROW_INC = 2'd0;
  localparam logic [1:0] DIR_ROW_DEC = 2'd1;
  localparam logic [1:0] DIR_COL_INC = 2'd2;
  localparam logic [1:0] DIR_COL_DEC = 2'd3;

  // Read slots: the four neighbours by direction, then the active cell
  localparam logic [2:0] SLOT_ACT = 3'd4;

  // Result count field
  localparam int unsigned COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [15:0] RECOVERY_RATE_RST = 16'd8880;

  typedef struct packed {
    logic       clr_we;    // clearing pass write
    logic       latch_in;  // capture input fields
    logic       rd_en;     // lattice read
    logic [2:0] rd_sel;    // slot being read
    logic       cap_en;    // capture neighbour read data
    logic [1:0] cap_sel;   // neighbour slot captured
    logic       eval;      // compute new states and count
    logic       wr_act;    // write back active cell
    logic       wr_nb;     // write back chosen neighbour
    logic       load_out;  // load result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_read;
  } dp_stat_t;

endpackage

FILE: sv/sirlat_ctrl.sv
// Controller state machine for the SIR lattice update block.
`timescale 1ns / 1ps

module sirlat_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sirlat_pkg::dp_stat_t stat,
  output sirlat_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_CLR    = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_RD     = 7'b0000100,
    S_EVAL   = 7'b0001000,
    S_WR_ACT = 7'b0010000,
    S_WR_NB  = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] rd_cnt_r, rd_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_cnt_r;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr_we = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          rd_cnt_nxt   = 3'd0;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = rd_cnt_r;
        // read data arrives in the cycle after its address
        cmd.cap_en  = (rd_cnt_r != 3'd0);
        cmd.cap_sel = 2'(rd_cnt_r - 3'd1);
        if (rd_cnt_r == sirlat_pkg::SLOT_ACT) begin
          state_nxt = S_EVAL;
        end else begin
          rd_cnt_nxt = rd_cnt_r + 3'd1;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.is_read ? S_FIN : S_WR_ACT;
      end
      S_WR_ACT: begin
        cmd.wr_act = 1'b1;
        state_nxt  = S_WR_NB;
      end
      S_WR_NB: begin
        cmd.wr_nb = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      rd_cnt_r    <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/sirlat_dp.sv
// Datapath: lattice memory, address generation, update rules and result register.
`timescale 1ns / 1ps

module sirlat_dp #(
  parameter int ROWS = 32,
  parameter int COLS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sirlat_pkg::ctrl_cmd_t cmd,
  output sirlat_pkg::dp_stat_t  stat,
  input  logic                  in_req_type,
  input  logic [4:0]            in_cell_row,
  input  logic [4:0]            in_cell_col,
  input  logic [1:0]            in_direction,
  input  logic [15:0]           in_draw_infect,
  input  logic [15:0]           in_draw_recover,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  output logic [1:0]            out_active_state,
  output logic [1:0]            out_neighbour_state,
  output logic [10:0]           out_infected_count,
  output logic                  out_epidemic_over
);

  localparam int DEPTH  = ROWS * COLS;
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLS);
  localparam int AW     = $clog2(DEPTH);
  localparam int CNTW   = $clog2(DEPTH + 1);
  localparam int SATW   = (CNTW > sirlat_pkg::COUNT_W) ? CNTW : sirlat_pkg::COUNT_W;
  localparam int CENTRE = (ROWS / 2) * COLS + (COLS / 2);

  logic [1:0]    mem [DEPTH];
  logic [1:0]    rdata_r;

  logic          req_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [1:0]    dir_r;
  logic [15:0]   da_r, db_r;
  logic [15:0]   rr_r;

  logic [1:0]    nb_st_r [4];
  logic [1:0]    act_new_r, nb_new_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] clr_addr_r;

  logic [1:0]    out_act_r, out_nb_r;
  logic [sirlat_pkg::COUNT_W-1:0] out_cnt_r;
  logic          out_over_r;

  logic [RW-1:0] row_mod, row_inc, row_dec;
  logic [CW-1:0] col_mod, col_inc, col_dec;
  logic [AW-1:0] rd_addr, act_addr, nb_addr, wr_addr;
  logic [1:0]    wr_data;
  logic          wr_en;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(AW'(r) * AW'(COLS) + AW'(c));
  endfunction

  // Input coordinates wrap onto the lattice; narrow enough for a lookup
  always_comb begin
    row_mod = '0;
    col_mod = '0;
    for (int i = 0; i < 32; i++) begin
      if (in_cell_row == 5'(i)) row_mod = RW'(i % ROWS);
      if (in_cell_col == 5'(i)) col_mod = CW'(i % COLS);
    end
  end

  assign row_inc = (row_r == RW'(ROWS - 1)) ? '0 : row_r + RW'(1);
  assign row_dec = (row_r == '0) ? RW'(ROWS - 1) : row_r - RW'(1);
  assign col_inc = (col_r == CW'(COLS - 1)) ? '0 : col_r + CW'(1);
  assign col_dec = (col_r == '0) ? CW'(COLS - 1) : col_r - CW'(1);

  function automatic logic [AW-1:0] nb_addr_of(
    input logic [1:0] d, input logic [RW-1:0] r, input logic [CW-1:0] c,
    input logic [RW-1:0] ri, input logic [RW-1:0] rd,
    input logic [CW-1:0] ci, input logic [CW-1:0] cd
  );
    logic [AW-1:0] a;
    case (d)
      sirlat_pkg::DIR_ROW_INC: a = cell_addr(ri, c);
      sirlat_pkg::DIR_ROW_DEC: a = cell_addr(rd, c);
      sirlat_pkg::DIR_COL_INC: a = cell_addr(r, ci);
      default:                 a = cell_addr(r, cd);
    endcase
    return a;
  endfunction

  assign act_addr = cell_addr(row_r, col_r);
  assign nb_addr  = nb_addr_of(dir_r, row_r, col_r, row_inc, row_dec, col_inc, col_dec);
  assign rd_addr  = (cmd.rd_sel == sirlat_pkg::SLOT_ACT) ? act_addr :
                    nb_addr_of(cmd.rd_sel[1:0], row_r, col_r, row_inc, row_dec,
                               col_inc, col_dec);

  always_comb begin
    wr_en   = cmd.clr_we | cmd.wr_act | cmd.wr_nb;
    wr_addr = clr_addr_r;
    wr_data = (clr_addr_r == AW'(CENTRE)) ? sirlat_pkg::CELL_INF : sirlat_pkg::CELL_SUSC;
    if (cmd.wr_act) begin
      wr_addr = act_addr;
      wr_data = act_new_r;
    end else if (cmd.wr_nb) begin
      wr_addr = nb_addr;
      wr_data = nb_new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Update rules: infection of the active cell uses the states read; spread and recovery test its updated state
  logic [1:0]  act0, nb0, a1, nb1, a2;
  logic [2:0]  m;
  logic [16:0] beta;
  logic [19:0] beta_m;
  logic        p_inf, a_inf, rec;

  always_comb begin
    act0 = rdata_r;
    nb0  = nb_st_r[dir_r];
    m    = '0;
    for (int d = 0; d < 4; d++) begin
      m = m + 3'(nb_st_r[d] == sirlat_pkg::CELL_INF);
    end
    beta   = 17'h10000 - {1'b0, rr_r};
    beta_m = 20'(beta) * 20'(m);
    p_inf  = (act0 == sirlat_pkg::CELL_SUSC) && ({2'b00, da_r, 2'b00} < beta_m);
    a1     = p_inf ? sirlat_pkg::CELL_INF : act0;
    a_inf  = ({1'b0, da_r} < beta) && (a1 == sirlat_pkg::CELL_INF) &&
             (nb0 == sirlat_pkg::CELL_SUSC);
    nb1    = a_inf ? sirlat_pkg::CELL_INF : nb0;
    rec    = (db_r < rr_r) && (a1 == sirlat_pkg::CELL_INF);
    a2     = rec ? sirlat_pkg::CELL_REC : a1;
    cnt_nxt = cnt_r + CNTW'(p_inf) + CNTW'(a_inf) - CNTW'(rec);
  end

  logic [SATW-1:0] cnt_ext;
  assign cnt_ext = SATW'(cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r <= in_req_type;
      row_r <= row_mod;
      col_r <= col_mod;
      dir_r <= in_direction;
      da_r  <= in_draw_infect;
      db_r  <= in_draw_recover;
    end
    if (cmd.cap_en) begin
      nb_st_r[cmd.cap_sel] <= rdata_r;
    end
    if (cmd.eval) begin
      if (req_r == sirlat_pkg::REQ_READ) begin
        act_new_r <= act0;
        nb_new_r  <= sirlat_pkg::CELL_SUSC;
      end else begin
        act_new_r <= a2;
        nb_new_r  <= nb1;
      end
    end
    if (cmd.load_out) begin
      out_act_r  <= act_new_r;
      out_nb_r   <= nb_new_r;
      out_cnt_r  <= (cnt_ext > SATW'(sirlat_pkg::COUNT_MAX)) ? sirlat_pkg::COUNT_MAX :
                    cnt_ext[sirlat_pkg::COUNT_W-1:0];
      out_over_r <= (cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_r       <= sirlat_pkg::RECOVERY_RATE_RST;
      cnt_r      <= CNTW'(1);
      clr_addr_r <= '0;
    end else begin
      if (cfg_we) begin
        rr_r <= cfg_wdata;
      end
      if (cmd.eval && req_r == sirlat_pkg::REQ_UPDATE) begin
        cnt_r <= cnt_nxt;
      end
      if (cmd.clr_we && !stat.clr_done) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  assign stat.clr_done = (clr_addr_r == AW'(DEPTH - 1));
  assign stat.is_read  = (req_r == sirlat_pkg::REQ_READ);

  assign out_active_state    = out_act_r;
  assign out_neighbour_state = out_nb_r;
  assign out_infected_count  = out_cnt_r;
  assign out_epidemic_over   = out_over_r;

endmodule

FILE: sv/sir_lattice_update_step.sv
// Top level of the SIR lattice update block.
`timescale 1ns / 1ps

// Stochastic SIR epidemic on a ROWS x COLS torus with von Neumann neighbours.
// After reset the block sweeps the lattice memory once, one cell per cycle
// (in_ready low meanwhile), leaving every cell susceptible except the
// centre, which is infected. The lattice lives in one memory with a single
// read and a single write port, so the four neighbours and the active cell
// are read one per cycle, then the new states are computed, then for an
// update the active cell and the chosen neighbour are written back one per
// cycle; a read skips the write-back. The controller then loads the result
// in its finish state and returns to idle before accepting the next item; a
// result that cannot be loaded because the previous one is still unaccepted
// holds the controller in the finish state until it can be. Items are
// processed one at a time; a finished result waits in the output register
// while the next item is accepted. The recovery rate may be written at any
// time the block is idle.
module sir_lattice_update_step #(
  parameter int ROWS = 32,
  parameter int COLS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [4:0]  in_cell_row,
  input  logic [4:0]  in_cell_col,
  input  logic [1:0]  in_direction,
  input  logic [15:0] in_draw_infect,
  input  logic [15:0] in_draw_recover,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_active_state,
  output logic [1:0]  out_neighbour_state,
  output logic [10:0] out_infected_count,
  output logic        out_epidemic_over,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  sirlat_pkg::ctrl_cmd_t cmd;
  sirlat_pkg::dp_stat_t  stat;

  sirlat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sirlat_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_req_type         (in_req_type),
    .in_cell_row         (in_cell_row),
    .in_cell_col         (in_cell_col),
    .in_direction        (in_direction),
    .in_draw_infect      (in_draw_infect),
    .in_draw_recover     (in_draw_recover),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_active_state    (out_active_state),
    .out_neighbour_state (out_neighbour_state),
    .out_infected_count  (out_infected_count),
    .out_epidemic_over   (out_epidemic_over)
  );

endmodule
